// ===== rtl/iolh_pkg.sv =====
// Shared types, constants and bin tables for the I/O latency and size histogram block.
`default_nettype none
package iolh_pkg;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_DELTA,
        ST_BIN_START,
        ST_BIN_WAIT,
        ST_HIST_READ,
        ST_HIST_WRITE,
        ST_RESULT
    } state_t;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    // Histogram selects.
    localparam logic [1:0] SEL_SIZE    = 2'd0;
    localparam logic [1:0] SEL_TOTAL   = 2'd1;
    localparam logic [1:0] SEL_REQUEST = 2'd2;
    localparam logic [1:0] SEL_QUEUE   = 2'd3;

    localparam int BIN_COUNT   = 461;
    localparam int HIST_KINDS  = 8;
    localparam int HIST_DEPTH  = HIST_KINDS * BIN_COUNT;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int BIN_W       = 9;
    localparam int DIV_W       = 30;
    localparam int QUO_W       = 7;
    localparam int STEP_W      = 1;
    localparam int CLASS_COUNT = 5;
    localparam int KIB_SHIFT   = 10;
    localparam logic [BIN_W-1:0] BIN_SAT = 9'd460;

    // Decade boundaries: in nanoseconds for latencies, in KiB for sizes.
    function automatic logic [63:0] threshold(input logic is_time, input logic [2:0] i);
        logic [63:0] t;
        case (i)
            3'd0:    t = is_time ? 64'd100000     : 64'd100;
            3'd1:    t = is_time ? 64'd1000000    : 64'd1000;
            3'd2:    t = is_time ? 64'd10000000   : 64'd10000;
            3'd3:    t = is_time ? 64'd100000000  : 64'd100000;
            default: t = is_time ? 64'd1000000000 : 64'd1000000;
        endcase
        return t;
    endfunction

    // Divisor that turns a value of decade k into its bin step.
    function automatic logic [DIV_W-1:0] divisor(input logic is_time, input logic [2:0] k);
        logic [DIV_W-1:0] d;
        case (k)
            3'd0:    d = is_time ? 30'd1000     : 30'd1;
            3'd1:    d = is_time ? 30'd10000    : 30'd10;
            3'd2:    d = is_time ? 30'd100000   : 30'd100;
            3'd3:    d = is_time ? 30'd1000000  : 30'd1000;
            default: d = is_time ? 30'd10000000 : 30'd10000;
        endcase
        return d;
    endfunction

    // First bin of decade k.
    function automatic logic [BIN_W-1:0] decade_base(input logic [2:0] k);
        logic [BIN_W-1:0] b;
        case (k)
            3'd0:    b = 9'd0;
            3'd1:    b = 9'd90;
            3'd2:    b = 9'd180;
            3'd3:    b = 9'd270;
            default: b = 9'd360;
        endcase
        return b;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       table_write;
        logic       load_value;
        logic       bin_start;
        logic       clear_we;
        logic       hist_we;
        logic       load_result;
        logic [1:0] sel;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic tag_ok;
        logic queued;
        logic dispatched;
        logic len_nz;
        logic bin_ok;
        logic bin_busy;
        logic clear_last;
    } status_t;

endpackage
`default_nettype wire

// ===== rtl/io_latency_size_histogram_unit.sv =====
// Top level of the storage request latency and size histogram block.
// Requests are taken one at a time. A queue insert, a histogram read, a dispatch that
// counts its queue latency and a completion each occupy the block until done; each
// counter update does the time subtraction, classes the value into a decade, finds
// the tens and units digits of the bin within the decade, hands the bin over, and
// reads and then writes the counter memory; a value that saturates to the last bin
// skips the two digit steps. After reset the block clears its 3688 counters, one a
// cycle, and accepts no request until the clearing pass is done. A finished result
// waits in the output register while the next request is accepted.
`default_nettype none
module io_latency_size_histogram_unit #(
    parameter int TAG_COUNT     = 64,
    parameter int COUNTER_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [5:0]  s_request_tag,
    input  wire logic [63:0] s_timestamp_ns,
    input  wire logic        s_is_write,
    input  wire logic [31:0] s_data_len_bytes,
    input  wire logic [1:0]  s_histogram_select,
    input  wire logic [8:0]  s_bin_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_bin_count
);

    iolh_pkg::cmd_t    cmd;
    iolh_pkg::status_t status;

    iolh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    iolh_datapath #(
        .TAG_COUNT     (TAG_COUNT),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_operation        (s_operation),
        .s_request_tag      (s_request_tag),
        .s_timestamp_ns     (s_timestamp_ns),
        .s_is_write         (s_is_write),
        .s_data_len_bytes   (s_data_len_bytes),
        .s_histogram_select (s_histogram_select),
        .s_bin_index        (s_bin_index),
        .m_bin_count        (m_bin_count)
    );

endmodule
`default_nettype wire

// ===== rtl/iolh_binner.sv =====
// Log-linear bin calculator: decade classing and a two-digit division by the decade step.
`default_nettype none
module iolh_binner (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic                       is_time,
    input  wire logic [63:0]                value,
    output logic                            busy,
    output logic [iolh_pkg::BIN_W-1:0]      bin
);

    logic                             busy_reg;
    logic [iolh_pkg::STEP_W-1:0]      step_reg;
    logic [iolh_pkg::DIV_W-1:0]       div_reg;
    logic [iolh_pkg::DIV_W-1:0]       rem_reg;
    logic [iolh_pkg::QUO_W-1:0]       quo_reg;
    logic [iolh_pkg::BIN_W-1:0]       base_reg;
    logic [2:0]                       decade;
    logic [iolh_pkg::DIV_W-1:0]       scale;
    logic [iolh_pkg::DIV_W-1:0]       taken;
    logic [3:0]                       digit;

    // Count the decade boundaries at or below the value.
    always_comb begin
        decade = 3'd0;
        for (int i = 0; i < iolh_pkg::CLASS_COUNT; i++) begin
            if (value >= iolh_pkg::threshold(is_time, 3'(i))) begin
                decade = decade + 3'd1;
            end
        end
    end

    // The quotient is below 100, so it is found as a tens digit and then a units digit,
    // each by comparing the remainder against the nine multiples of the step.
    always_comb begin
        scale = (step_reg == '0) ? (div_reg << 3) + (div_reg << 1) : div_reg;
        digit = 4'd0;
        taken = '0;
        for (int j = 1; j < 10; j++) begin
            if (rem_reg >= iolh_pkg::DIV_W'(j) * scale) begin
                digit = 4'(j);
                taken = iolh_pkg::DIV_W'(j) * scale;
            end
        end
    end

    // One quotient digit per cycle, tens first.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            quo_reg <= '0;
            if (decade == 3'(iolh_pkg::CLASS_COUNT)) begin
                base_reg <= iolh_pkg::BIN_SAT;
                busy_reg <= 1'b0;
            end else begin
                base_reg <= iolh_pkg::decade_base(decade);
                div_reg  <= iolh_pkg::divisor(is_time, decade);
                rem_reg  <= value[iolh_pkg::DIV_W-1:0];
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
        end else if (busy_reg) begin
            rem_reg <= rem_reg - taken;
            if (step_reg == '0) begin
                quo_reg  <= iolh_pkg::QUO_W'(digit) * iolh_pkg::QUO_W'(10);
                step_reg <= iolh_pkg::STEP_W'(1);
            end else begin
                quo_reg  <= quo_reg + iolh_pkg::QUO_W'(digit);
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign bin  = base_reg + iolh_pkg::BIN_W'(quo_reg);

endmodule
`default_nettype wire

// ===== rtl/iolh_datapath.sv =====
// Datapath: request capture, tag time stores, binning and the histogram counter memory.
`default_nettype none
module iolh_datapath #(
    parameter int TAG_COUNT     = 64,
    parameter int COUNTER_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire iolh_pkg::cmd_t        cmd,
    output iolh_pkg::status_t          status,
    input  wire logic [1:0]            s_operation,
    input  wire logic [5:0]            s_request_tag,
    input  wire logic [63:0]           s_timestamp_ns,
    input  wire logic                  s_is_write,
    input  wire logic [31:0]           s_data_len_bytes,
    input  wire logic [1:0]            s_histogram_select,
    input  wire logic [8:0]            s_bin_index,
    output logic [31:0]                m_bin_count
);

    localparam int TW    = $clog2(TAG_COUNT);
    localparam int EXT_W = (COUNTER_WIDTH > 32) ? COUNTER_WIDTH : 32;

    iolh_pkg::op_t  op_reg;
    logic [5:0]     tag_reg;
    logic [63:0]    now_reg;
    logic           wr_reg;
    logic [31:0]    len_reg;
    logic [1:0]     hsel_reg;
    logic [8:0]     bin_idx_reg;

    logic [TW-1:0]  tag_idx;
    logic           tag_ok;
    logic [63:0]    qt_mem [TAG_COUNT];
    logic [63:0]    dt_mem [TAG_COUNT];
    logic [63:0]    qt_q;
    logic [63:0]    dt_q;
    logic [TAG_COUNT-1:0] queued_valid_reg;
    logic [TAG_COUNT-1:0] dispatch_valid_reg;

    logic [63:0]    value_reg;
    logic           is_time_reg;
    logic           bin_busy;
    logic [iolh_pkg::BIN_W-1:0] bin_out;

    logic [COUNTER_WIDTH-1:0]   hist_mem [iolh_pkg::HIST_DEPTH];
    logic [COUNTER_WIDTH-1:0]   hist_q;
    logic [COUNTER_WIDTH-1:0]   hist_inc;
    logic [iolh_pkg::HIST_AW-1:0] clr_addr_reg;
    logic [iolh_pkg::HIST_AW-1:0] hist_addr;
    logic [1:0]     addr_sel;
    logic [8:0]     addr_bin;
    logic [EXT_W-1:0] q_ext;
    logic [31:0]    rd_count;
    logic [31:0]    m_bin_count_reg;
    logic           bin_ok;
    logic           is_read;

    // Request capture.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg      <= iolh_pkg::op_t'(s_operation);
            tag_reg     <= s_request_tag;
            now_reg     <= s_timestamp_ns;
            wr_reg      <= s_is_write;
            len_reg     <= s_data_len_bytes;
            hsel_reg    <= s_histogram_select;
            bin_idx_reg <= s_bin_index;
        end
    end

    assign tag_idx = TW'(tag_reg);
    assign tag_ok  = (32'(tag_reg) < TAG_COUNT);
    assign is_read = (op_reg == iolh_pkg::OP_READ);
    assign bin_ok  = (bin_idx_reg < 9'(iolh_pkg::BIN_COUNT));

    // Queue and dispatch time stores.
    always_ff @(posedge aclk) begin
        if (cmd.table_write && tag_ok) begin
            if (op_reg == iolh_pkg::OP_INSERT) begin
                qt_mem[tag_idx] <= now_reg;
            end
            if (op_reg == iolh_pkg::OP_DISPATCH) begin
                dt_mem[tag_idx] <= now_reg;
            end
        end
        qt_q <= qt_mem[tag_idx];
        dt_q <= dt_mem[tag_idx];
    end

    // Per-tag valid marks.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queued_valid_reg   <= '0;
            dispatch_valid_reg <= '0;
        end else if (cmd.table_write && tag_ok) begin
            if (op_reg == iolh_pkg::OP_INSERT) begin
                queued_valid_reg[tag_idx] <= 1'b1;
            end
            if (op_reg == iolh_pkg::OP_DISPATCH) begin
                dispatch_valid_reg[tag_idx] <= 1'b1;
            end
        end
    end

    // Value to be binned: size in KiB or elapsed nanoseconds.
    always_ff @(posedge aclk) begin
        if (cmd.load_value) begin
            case (cmd.sel)
                iolh_pkg::SEL_SIZE: begin
                    value_reg   <= 64'(len_reg >> iolh_pkg::KIB_SHIFT);
                    is_time_reg <= 1'b0;
                end
                iolh_pkg::SEL_REQUEST: begin
                    value_reg   <= now_reg - dt_q;
                    is_time_reg <= 1'b1;
                end
                default: begin
                    value_reg   <= now_reg - qt_q;
                    is_time_reg <= 1'b1;
                end
            endcase
        end
    end

    iolh_binner u_binner (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.bin_start),
        .is_time (is_time_reg),
        .value   (value_reg),
        .busy    (bin_busy),
        .bin     (bin_out)
    );

    // Counter address: kind times bin count plus bin.
    assign addr_sel  = is_read ? hsel_reg : cmd.sel;
    assign addr_bin  = is_read ? bin_idx_reg : bin_out;
    assign hist_addr = iolh_pkg::HIST_AW'({wr_reg, addr_sel})
                       * iolh_pkg::HIST_AW'(iolh_pkg::BIN_COUNT)
                       + iolh_pkg::HIST_AW'(addr_bin);
    assign hist_inc  = (hist_q == '1) ? hist_q : hist_q + 1'b1;

    // Clearing pass address after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_we) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Histogram counter memory.
    always_ff @(posedge aclk) begin
        if (cmd.clear_we) begin
            hist_mem[clr_addr_reg] <= '0;
        end else if (cmd.hist_we) begin
            hist_mem[hist_addr] <= hist_inc;
        end
        hist_q <= hist_mem[hist_addr];
    end

    // Read-back value limited to 32 bits.
    assign q_ext    = EXT_W'(hist_q);
    assign rd_count = (q_ext > EXT_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : q_ext[31:0];

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            m_bin_count_reg <= (is_read && bin_ok) ? rd_count : 32'd0;
        end
    end

    assign m_bin_count = m_bin_count_reg;

    always_comb begin
        status.op         = op_reg;
        status.tag_ok     = tag_ok;
        status.queued     = queued_valid_reg[tag_idx];
        status.dispatched = dispatch_valid_reg[tag_idx];
        status.len_nz     = (len_reg != 32'd0);
        status.bin_ok     = bin_ok;
        status.bin_busy   = bin_busy;
        status.clear_last = (clr_addr_reg == iolh_pkg::HIST_AW'(iolh_pkg::HIST_DEPTH - 1));
    end

endmodule
`default_nettype wire

// ===== rtl/iolh_ctrl.sv =====
// Controller state machine: sequences lookups, counter updates and result delivery.
`default_nettype none
module iolh_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire iolh_pkg::status_t  status,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output iolh_pkg::cmd_t          cmd
);

    iolh_pkg::state_t state_reg;
    iolh_pkg::state_t state_next;
    logic [3:0]       pending_reg;
    logic [3:0]       pending_next;
    logic [3:0]       pending_fill;
    logic [3:0]       pending_left;
    logic [1:0]       cur_sel;
    logic             m_valid_reg;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Lowest pending histogram goes first.
    always_comb begin
        if (pending_reg[0]) begin
            cur_sel = iolh_pkg::SEL_SIZE;
        end else if (pending_reg[1]) begin
            cur_sel = iolh_pkg::SEL_TOTAL;
        end else if (pending_reg[2]) begin
            cur_sel = iolh_pkg::SEL_REQUEST;
        end else begin
            cur_sel = iolh_pkg::SEL_QUEUE;
        end
        pending_left = pending_reg & ~(4'd1 << cur_sel);
    end

    // Counter updates that this request calls for.
    always_comb begin
        pending_fill = 4'd0;
        if (status.tag_ok && status.queued) begin
            case (status.op)
                iolh_pkg::OP_DISPATCH: pending_fill = 4'b1000;
                iolh_pkg::OP_COMPLETE: pending_fill = {1'b0, status.dispatched, 1'b1,
                                                       status.len_nz};
                default:               pending_fill = 4'd0;
            endcase
        end
    end

    // Next state.
    always_comb begin
        state_next   = state_reg;
        pending_next = pending_reg;
        case (state_reg)
            iolh_pkg::ST_CLEAR: begin
                if (status.clear_last) state_next = iolh_pkg::ST_IDLE;
            end
            iolh_pkg::ST_IDLE: begin
                if (s_valid) state_next = iolh_pkg::ST_LOOKUP;
            end
            iolh_pkg::ST_LOOKUP: state_next = iolh_pkg::ST_DECIDE;
            iolh_pkg::ST_DECIDE: begin
                pending_next = pending_fill;
                if (status.op == iolh_pkg::OP_READ) begin
                    state_next = status.bin_ok ? iolh_pkg::ST_HIST_READ : iolh_pkg::ST_RESULT;
                end else if (pending_fill != 4'd0) begin
                    state_next = iolh_pkg::ST_DELTA;
                end else begin
                    state_next = iolh_pkg::ST_RESULT;
                end
            end
            iolh_pkg::ST_DELTA:     state_next = iolh_pkg::ST_BIN_START;
            iolh_pkg::ST_BIN_START: state_next = iolh_pkg::ST_BIN_WAIT;
            iolh_pkg::ST_BIN_WAIT: begin
                if (!status.bin_busy) state_next = iolh_pkg::ST_HIST_READ;
            end
            iolh_pkg::ST_HIST_READ: begin
                state_next = (status.op == iolh_pkg::OP_READ) ? iolh_pkg::ST_RESULT
                                                              : iolh_pkg::ST_HIST_WRITE;
            end
            iolh_pkg::ST_HIST_WRITE: begin
                pending_next = pending_left;
                state_next   = (pending_left != 4'd0) ? iolh_pkg::ST_DELTA
                                                      : iolh_pkg::ST_RESULT;
            end
            iolh_pkg::ST_RESULT: begin
                if (out_free) state_next = iolh_pkg::ST_IDLE;
            end
            default: state_next = iolh_pkg::ST_IDLE;
        endcase
    end

    // Commands per state.
    always_comb begin
        cmd             = '0;
        cmd.sel         = cur_sel;
        cmd.clear_we    = (state_reg == iolh_pkg::ST_CLEAR);
        cmd.capture     = (state_reg == iolh_pkg::ST_IDLE) && s_valid;
        cmd.table_write = (state_reg == iolh_pkg::ST_DECIDE);
        cmd.load_value  = (state_reg == iolh_pkg::ST_DELTA);
        cmd.bin_start   = (state_reg == iolh_pkg::ST_BIN_START);
        cmd.hist_we     = (state_reg == iolh_pkg::ST_HIST_WRITE);
        cmd.load_result = (state_reg == iolh_pkg::ST_RESULT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= iolh_pkg::ST_CLEAR;
            pending_reg <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            if (cmd.load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = (state_reg == iolh_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/iolh_checker.sv =====
// Port-level checks for the histogram block, bound to its top level.
`default_nettype none
module iolh_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_bin_count
);

    // A stalled result holds its value.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bin_count))
        else $error("result changed while stalled");

    // Only one request is in work at a time.
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request accepted while one is in work");

    // The clearing pass keeps requests out right after reset.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("request or result allowed during the clearing pass");

endmodule

bind io_latency_size_histogram_unit iolh_checker u_iolh_checker (.*);
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the storage request latency and size histogram block.
`default_nettype none
module tb_top;

    localparam int GAP_MAX    = 18;
    localparam int DOG_LIMIT  = 20000;
    localparam int DRAIN_WAIT = 60;
    localparam int RAND_ITEMS = 700;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [5:0]  s_request_tag;
    logic [63:0] s_timestamp_ns;
    logic        s_is_write;
    logic [31:0] s_data_len_bytes;
    logic [1:0]  s_histogram_select;
    logic [8:0]  s_bin_index;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_bin_count;

    // Model state kept alongside the block.
    logic [63:0] queue_ts [64];
    logic        queued   [64];
    logic [63:0] disp_ts  [64];
    logic        disp_seen[64];
    logic [31:0] hist     [iolh_pkg::HIST_DEPTH];
    int          touched[$];
    logic [31:0] pending_counts[$];

    logic        no_idle;
    logic [63:0] now_ns;
    int          requests_sent;
    int          results_seen;
    int          mismatches;
    int          quiet_cycles;

    io_latency_size_histogram_unit u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_request_tag      (s_request_tag),
        .s_timestamp_ns     (s_timestamp_ns),
        .s_is_write         (s_is_write),
        .s_data_len_bytes   (s_data_len_bytes),
        .s_histogram_select (s_histogram_select),
        .s_bin_index        (s_bin_index),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_bin_count        (m_bin_count)
    );

    // Clock generation.
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Log-linear bin of a value: exact below 100, then 90 bins per decade.
    function automatic logic [8:0] log_bin(input logic [63:0] v);
        if (v < 64'd100) return v[8:0];
        if (v < 64'd1000) return 9'(90 + v / 10);
        if (v < 64'd10000) return 9'(180 + v / 100);
        if (v < 64'd100000) return 9'(270 + v / 1000);
        if (v < 64'd1000000) return 9'(360 + v / 10000);
        return iolh_pkg::BIN_SAT;
    endfunction

    function automatic logic [8:0] elapsed_bin(input logic [63:0] later, input logic [63:0] start);
        logic [63:0] d;
        d = later - start;
        return log_bin(d / 64'd1000);
    endfunction

    function automatic int pick_gap();
        if (no_idle || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    // Increments one counter, saturating at full scale.
    task automatic count_bin(input logic wr, input logic [1:0] sel, input logic [8:0] bin);
        int idx;
        idx = (int'(wr) * 4 + int'(sel)) * iolh_pkg::BIN_COUNT + int'(bin);
        if (hist[idx] != 32'hFFFF_FFFF) hist[idx]++;
        touched.push_back(idx);
    endtask

    // Applies one accepted request to the model and returns its expected count.
    task automatic apply_request(input iolh_pkg::op_t op, input logic [5:0] tag,
                                 input logic [63:0] ts,
                                 input logic wr, input logic [31:0] len,
                                 input logic [1:0] sel, input logic [8:0] bin,
                                 output logic [31:0] cnt);
        cnt = '0;
        case (op)
            iolh_pkg::OP_READ: begin
                if (bin < iolh_pkg::BIN_COUNT)
                    cnt = hist[(int'(wr) * 4 + int'(sel)) * iolh_pkg::BIN_COUNT + int'(bin)];
            end
            iolh_pkg::OP_INSERT: begin
                queue_ts[tag] = ts;
                queued[tag]   = 1'b1;
            end
            iolh_pkg::OP_DISPATCH: begin
                if (queued[tag])
                    count_bin(wr, iolh_pkg::SEL_QUEUE, elapsed_bin(ts, queue_ts[tag]));
                disp_ts[tag]   = ts;
                disp_seen[tag] = 1'b1;
            end
            default: begin
                if (queued[tag]) begin
                    if (len != 0)
                        count_bin(wr, iolh_pkg::SEL_SIZE,
                                  log_bin(64'(len >> iolh_pkg::KIB_SHIFT)));
                    count_bin(wr, iolh_pkg::SEL_TOTAL, elapsed_bin(ts, queue_ts[tag]));
                    if (disp_seen[tag])
                        count_bin(wr, iolh_pkg::SEL_REQUEST, elapsed_bin(ts, disp_ts[tag]));
                end
            end
        endcase
    endtask

    // Presents one request and waits until it is accepted.
    task automatic send_request(input iolh_pkg::op_t op, input logic [5:0] tag,
                                input logic [63:0] ts,
                                input logic wr, input logic [31:0] len,
                                input logic [1:0] sel, input logic [8:0] bin);
        int gap;
        logic [31:0] cnt;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_operation        <= op;
        s_request_tag      <= tag;
        s_timestamp_ns     <= ts;
        s_is_write         <= wr;
        s_data_len_bytes   <= len;
        s_histogram_select <= sel;
        s_bin_index        <= bin;
        s_valid            <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        apply_request(op, tag, ts, wr, len, sel, bin, cnt);
        pending_counts.push_back(cnt);
        requests_sent++;
    endtask

    task automatic send_read(input logic wr, input logic [1:0] sel, input logic [8:0] bin);
        send_request(iolh_pkg::OP_READ, 6'($urandom), {$urandom, $urandom}, wr, $urandom,
                     sel, bin);
    endtask

    // Reads back a counter that has been incremented at some point, or a random one if none has been.
    task automatic read_touched();
        int idx;
        if (touched.size() == 0) begin
            send_read(1'($urandom), 2'($urandom), 9'($urandom_range(0, 511)));
        end else begin
            idx = touched[$urandom_range(0, touched.size() - 1)];
            send_read(1'(idx / (4 * iolh_pkg::BIN_COUNT)),
                      2'((idx / iolh_pkg::BIN_COUNT) % 4),
                      9'(idx % iolh_pkg::BIN_COUNT));
        end
    endtask

    // Elapsed time spread over every scale, from nanoseconds to the full 64 bits.
    function automatic logic [63:0] rand_delta();
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    // Result checker: stalls at random and compares each count in order.
    initial begin
        int stall;
        logic [31:0] want;
        m_ready <= 1'b0;
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            results_seen++;
            if (pending_counts.size() == 0) begin
                $error("unexpected result: bin_count %0d", m_bin_count);
                mismatches++;
            end else begin
                want = pending_counts.pop_front();
                if (m_bin_count !== want) begin
                    $error("bin_count: expected %0d, actual %0d", want, m_bin_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake; allows for the clearing pass.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= DOG_LIMIT) begin
                $display("timeout after %0d idle cycles", quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Empty histograms, every select and direction, and bins past the end.
    task automatic test_empty_reads();
        send_read(1'b0, iolh_pkg::SEL_SIZE, 9'd0);
        send_read(1'b1, iolh_pkg::SEL_QUEUE, 9'd460);
        send_read(1'b0, iolh_pkg::SEL_TOTAL, 9'd461);
        send_read(1'b1, iolh_pkg::SEL_REQUEST, 9'd511);
    endtask

    // Decade edges, backward time, zero and full lengths, unqueued tags.
    task automatic test_edges();
        no_idle = 1'b1;
        // Dispatch and completion of a tag never queued count nothing.
        send_request(iolh_pkg::OP_DISPATCH, 6'd63, 64'd5000, 1'b1, 32'd4096,
                     iolh_pkg::SEL_SIZE, 9'd0);
        send_request(iolh_pkg::OP_COMPLETE, 6'd62, 64'd9000, 1'b0, 32'd4096,
                     iolh_pkg::SEL_SIZE, 9'd0);
        no_idle = 1'b0;
        send_request(iolh_pkg::OP_INSERT, 6'd0, 64'd0, 1'b0, 32'd0, iolh_pkg::SEL_SIZE, 9'd0);
        send_request(iolh_pkg::OP_DISPATCH, 6'd0, 64'd99_999, 1'b0, 32'd0,
                     iolh_pkg::SEL_SIZE, 9'd0);
        send_request(iolh_pkg::OP_COMPLETE, 6'd0, 64'd100_000, 1'b0, 32'd0,
                     iolh_pkg::SEL_SIZE, 9'd0);
        send_request(iolh_pkg::OP_COMPLETE, 6'd0, 64'd999_999_999, 1'b1, 32'hFFFF_FFFF,
                     iolh_pkg::SEL_SIZE, 9'd0);
        send_request(iolh_pkg::OP_COMPLETE, 6'd0, 64'd1_000_000_000, 1'b1, 32'd102_399,
                     iolh_pkg::SEL_SIZE, 9'd0);
        send_request(iolh_pkg::OP_COMPLETE, 6'd0, 64'd9_999_999, 1'b0, 32'd1_024_000,
                     iolh_pkg::SEL_SIZE, 9'd0);
        // Time going backward wraps to a huge elapsed value.
        send_request(iolh_pkg::OP_INSERT, 6'd21, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'd1,
                     iolh_pkg::SEL_SIZE, 9'd0);
        send_request(iolh_pkg::OP_DISPATCH, 6'd21, 64'd10, 1'b1, 32'd1,
                     iolh_pkg::SEL_SIZE, 9'd0);
        send_request(iolh_pkg::OP_COMPLETE, 6'd21, 64'd5, 1'b1, 32'd1023,
                     iolh_pkg::SEL_SIZE, 9'd0);
        send_read(1'b0, iolh_pkg::SEL_QUEUE, 9'd99);
        send_read(1'b0, iolh_pkg::SEL_TOTAL, 9'd100);
        send_read(1'b1, iolh_pkg::SEL_TOTAL, 9'd459);
        send_read(1'b1, iolh_pkg::SEL_SIZE, 9'd460);
        send_read(1'b1, iolh_pkg::SEL_REQUEST, 9'd460);
        send_read(1'b1, iolh_pkg::SEL_QUEUE, 9'd460);
        send_read(1'b0, iolh_pkg::SEL_SIZE, 9'd270);
    endtask

    // Mostly complete request lifecycles with random times, plus read-backs and random noise.
    task automatic test_random_traffic();
        logic [5:0] tag;
        logic       wr;
        for (int n = 0; n < RAND_ITEMS; ) begin
            if (n % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
            tag = 6'($urandom);
            wr  = 1'($urandom);
            case ($urandom_range(0, 9))
                0, 1: begin
                    send_request(iolh_pkg::op_t'(2'($urandom)), 6'($urandom),
                                 {$urandom, $urandom}, 1'($urandom),
                                 $urandom, 2'($urandom), 9'($urandom));
                    n++;
                end
                2, 3: begin
                    read_touched();
                    n++;
                end
                default: begin
                    now_ns += rand_delta();
                    send_request(iolh_pkg::OP_INSERT, tag, now_ns, wr, $urandom,
                                 2'($urandom), 9'($urandom));
                    if ($urandom_range(0, 3) != 0) begin
                        now_ns += rand_delta();
                        send_request(iolh_pkg::OP_DISPATCH, tag, now_ns, wr, $urandom,
                                     2'($urandom), 9'($urandom));
                    end
                    now_ns += rand_delta();
                    send_request(iolh_pkg::OP_COMPLETE, tag, now_ns, wr,
                                 $urandom >> $urandom_range(0, 31),
                                 2'($urandom), 9'($urandom));
                    read_touched();
                    n += 4;
                end
            endcase
        end
        no_idle = 1'b0;
    endtask

    // Sequencing of the tests and the final verdict.
    initial begin
        for (int i = 0; i < iolh_pkg::HIST_DEPTH; i++) hist[i] = '0;
        for (int i = 0; i < 64; i++) begin
            queued[i]    = 1'b0;
            disp_seen[i] = 1'b0;
        end
        no_idle            = 1'b0;
        now_ns             = '0;
        requests_sent      = 0;
        results_seen       = 0;
        mismatches         = 0;
        quiet_cycles       = 0;
        aresetn            <= 1'b0;
        s_valid            <= 1'b0;
        s_operation        <= '0;
        s_request_tag      <= '0;
        s_timestamp_ns     <= '0;
        s_is_write         <= 1'b0;
        s_data_len_bytes   <= '0;
        s_histogram_select <= '0;
        s_bin_index        <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_reads();
        test_edges();
        test_random_traffic();
        s_valid <= 1'b0;

        while (pending_counts.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Sent %0d requests and checked %0d results, %0d counters incremented.",
                 requests_sent, results_seen, touched.size());
        $display("Mismatches: %0d.", mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/iolh_pkg.sv
rtl/iolh_binner.sv
rtl/iolh_datapath.sv
rtl/iolh_ctrl.sv
rtl/io_latency_size_histogram_unit.sv
rtl/iolh_checker.sv
test/tb_top.sv
